[design/fixed_block_pool_allocator_core_macros.svh]
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core_macros.svh
// assertion helpers shared by the allocator checker
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_CORE_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, masked during reset
`define FBPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbpa check failed");

// next-cycle implication, masked during reset
`define FBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbpa check failed");

`endif

[design/fbpa_pkg.sv]
// ----------------------------------------------------------------------------
// fbpa_pkg
// types and constants of the fixed block pool allocator
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 16;
    localparam int ITEMS_W    = 11;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 32;
    localparam int MUL_A_W    = 16;
    localparam int MUL_B_W    = SIZE_W + 1;
    localparam int PROD_W     = 33;
    localparam int DIV_CNT_W  = $clog2(ADDR_W);
    localparam int TAG_W      = 2;

    localparam int POOL_DEPTH_DEF = 1024;

    // commands
    localparam logic [CMD_W-1:0] CMD_INIT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOMEM     = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNALIGNED = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_DOUBLE    = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_ITEMS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_BASE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MEMORY_BYTES = 2'd3;

    // link entry tags
    localparam logic [TAG_W-1:0] LINK_NEXT  = 2'd0;
    localparam logic [TAG_W-1:0] LINK_END   = 2'd1;
    localparam logic [TAG_W-1:0] LINK_TAKEN = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] release_address;
    } fbpa_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   grant_addr;
        logic [ITEMS_W-1:0]  free_count;
    } fbpa_rsp_t;

    // request to the shared multiply / divide unit
    typedef struct packed {
        logic               start;
        logic               is_div;
        logic [ADDR_W-1:0]  op_a;
        logic [MUL_B_W-1:0] op_b;
    } fbpa_md_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] product;
        logic [ADDR_W-1:0] quotient;
        logic              rem_zero;
    } fbpa_md_rsp_t;

endpackage

`default_nettype wire

[design/fbpa_ram.sv]
// ----------------------------------------------------------------------------
// fbpa_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/fbpa_muldiv.sv]
// ----------------------------------------------------------------------------
// fbpa_muldiv
// shared unit: 16x17 multiply or bit-serial restoring divide
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_muldiv (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fbpa_pkg::fbpa_md_req_t md_req,
    output fbpa_pkg::fbpa_md_rsp_t      md_rsp
);

    localparam logic [fbpa_pkg::DIV_CNT_W-1:0] CNT_LAST =
        fbpa_pkg::DIV_CNT_W'(fbpa_pkg::ADDR_W - 1);

    logic                               run_reg, run_next;
    logic [fbpa_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                               done_reg, done_next;
    logic [fbpa_pkg::PROD_W-1:0]        prod_reg, prod_next;
    logic [fbpa_pkg::ADDR_W-1:0]        quo_reg, quo_next;
    logic [fbpa_pkg::SIZE_W-1:0]        rem_reg, rem_next;
    logic [fbpa_pkg::SIZE_W-1:0]        div_reg, div_next;
    logic [fbpa_pkg::SIZE_W:0]          rem_shift;
    logic [fbpa_pkg::SIZE_W:0]          rem_sub;
    logic                               fits;

    always_comb
    begin
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        prod_next = prod_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;

        rem_shift = {rem_reg, quo_reg[fbpa_pkg::ADDR_W-1]};
        rem_sub   = rem_shift - {1'b0, div_reg};
        fits      = (rem_shift >= {1'b0, div_reg});

        if (md_req.start)
        begin
            if (md_req.is_div)
            begin
                run_next = 1'b1;
                cnt_next = '0;
                quo_next = md_req.op_a;
                rem_next = '0;
                div_next = md_req.op_b[fbpa_pkg::SIZE_W-1:0];
            end
            else
            begin
                prod_next = fbpa_pkg::PROD_W'(md_req.op_a[fbpa_pkg::MUL_A_W-1:0])
                          * fbpa_pkg::PROD_W'(md_req.op_b);
                done_next = 1'b1;
            end
        end
        else if (run_reg)
        begin
            // one quotient bit per cycle
            rem_next = fits ? rem_sub[fbpa_pkg::SIZE_W-1:0] : rem_shift[fbpa_pkg::SIZE_W-1:0];
            quo_next = {quo_reg[fbpa_pkg::ADDR_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign md_rsp.done     = done_reg;
    assign md_rsp.product  = prod_reg;
    assign md_rsp.quotient = quo_reg;
    assign md_rsp.rem_zero = (rem_reg == '0);

endmodule

`default_nettype wire

[design/fixed_block_pool_allocator_core.sv]
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core
// equal-size block pool with a linked free list in an on-chip link ram
// ----------------------------------------------------------------------------
// A request (init, get or release) is taken at a clock edge with start high
// and busy low. Each request gives exactly one result, shown on result for a
// single cycle with done high; the receiver takes it there and cannot stall.
// Cycles from acceptance to the done cycle:
//   get           2 (link ram read and address multiply, then write back)
//   get on empty, init with a bad item count or zero block size,
//   unused command: 1
//   release       35 (32-step bit-serial divide in the shared unit, then
//                 a link ram read and a write); 34 when the address is
//                 unaligned or out of range
//   init          2 + pool_items (multiply check, then one link entry written
//                 per cycle); 2 when the pool does not fit in memory
// busy stays high until the cycle before done, so a new request may be taken
// in the same cycle a result is shown. Configuration writes land at once and
// are meant for idle periods; init copies block size and base for later use.
// Reset leaves the pool empty (free count zero, no valid entries) and the
// registers at their defaults; the link ram needs no clearing since it is
// only read at entries that init has written.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_pool_allocator_core #(
    parameter int POOL_DEPTH = fbpa_pkg::POOL_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire fbpa_pkg::fbpa_req_t               req,
    output logic                                   busy,
    output logic                                   done,
    output fbpa_pkg::fbpa_rsp_t                    result,
    input  wire logic                              cfg_we,
    input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [fbpa_pkg::CFG_W-1:0]        cfg_data
);

    localparam int IDX_W  = $clog2(POOL_DEPTH);
    localparam int LINK_W = fbpa_pkg::TAG_W + IDX_W;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_INIT_CHK  = 3'd1;
    localparam logic [2:0] S_INIT_WALK = 3'd2;
    localparam logic [2:0] S_GET_WR    = 3'd3;
    localparam logic [2:0] S_REL_DIV   = 3'd4;
    localparam logic [2:0] S_REL_CHK   = 3'd5;

    // configuration registers
    logic [fbpa_pkg::SIZE_W-1:0]  block_bytes_reg;
    logic [fbpa_pkg::ITEMS_W-1:0] pool_items_reg;
    logic [fbpa_pkg::ADDR_W-1:0]  buffer_base_reg;
    logic [fbpa_pkg::ADDR_W-1:0]  memory_bytes_reg;

    logic [2:0]                   state_reg, state_next;
    logic                         head_valid_reg, head_valid_next;
    logic [IDX_W-1:0]             head_reg, head_next;
    logic [fbpa_pkg::ITEMS_W-1:0] free_reg, free_next;
    logic [fbpa_pkg::ITEMS_W-1:0] limit_reg, limit_next;
    logic [fbpa_pkg::SIZE_W-1:0]  held_size_reg, held_size_next;
    logic [fbpa_pkg::ADDR_W-1:0]  held_base_reg, held_base_next;
    logic [fbpa_pkg::ITEMS_W-1:0] walk_reg, walk_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic                         neg_reg, neg_next;
    logic                         done_reg, done_next;
    fbpa_pkg::fbpa_rsp_t          result_reg, result_next;

    fbpa_pkg::fbpa_md_req_t       md_req;
    fbpa_pkg::fbpa_md_rsp_t       md_rsp;

    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [LINK_W-1:0]            ram_wdata;
    logic [IDX_W-1:0]             ram_raddr;
    logic [LINK_W-1:0]            ram_rdata;
    logic [fbpa_pkg::TAG_W-1:0]   rd_tag;

    logic [fbpa_pkg::ADDR_W-1:0]  diff;
    logic [fbpa_pkg::ADDR_W-1:0]  mag;

    assign rd_tag = ram_rdata[LINK_W-1 -: fbpa_pkg::TAG_W];

    always_comb
    begin
        state_next      = state_reg;
        head_valid_next = head_valid_reg;
        head_next       = head_reg;
        free_next       = free_reg;
        limit_next      = limit_reg;
        held_size_next  = held_size_reg;
        held_base_next  = held_base_reg;
        walk_next       = walk_reg;
        idx_next        = idx_reg;
        neg_next        = neg_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        md_req          = '0;
        ram_we          = 1'b0;
        ram_waddr       = head_reg;
        ram_wdata       = '0;
        ram_raddr       = head_reg;

        // signed offset of the released address from the pool base
        diff = req.release_address - held_base_reg;
        mag  = diff[fbpa_pkg::ADDR_W-1] ? (fbpa_pkg::ADDR_W'(0) - diff) : diff;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (req.command)
                        fbpa_pkg::CMD_INIT:
                        begin
                            if (pool_items_reg == '0 || block_bytes_reg == '0 ||
                                32'(pool_items_reg) > 32'(POOL_DEPTH))
                            begin
                                done_next              = 1'b1;
                                result_next.status     = fbpa_pkg::STATUS_NOMEM;
                                result_next.grant_addr = '0;
                            end
                            else
                            begin
                                md_req.start  = 1'b1;
                                md_req.is_div = 1'b0;
                                md_req.op_a   = fbpa_pkg::ADDR_W'(pool_items_reg);
                                md_req.op_b   = fbpa_pkg::MUL_B_W'(block_bytes_reg)
                                              + fbpa_pkg::MUL_B_W'(4);
                                state_next    = S_INIT_CHK;
                            end
                        end
                        fbpa_pkg::CMD_GET:
                        begin
                            if (!head_valid_reg)
                            begin
                                done_next              = 1'b1;
                                result_next.status     = fbpa_pkg::STATUS_EMPTY;
                                result_next.grant_addr = '0;
                            end
                            else
                            begin
                                ram_raddr     = head_reg;
                                md_req.start  = 1'b1;
                                md_req.is_div = 1'b0;
                                md_req.op_a   = fbpa_pkg::ADDR_W'(head_reg);
                                md_req.op_b   = fbpa_pkg::MUL_B_W'(held_size_reg);
                                state_next    = S_GET_WR;
                            end
                        end
                        fbpa_pkg::CMD_RELEASE:
                        begin
                            md_req.start  = 1'b1;
                            md_req.is_div = 1'b1;
                            md_req.op_a   = mag;
                            md_req.op_b   = fbpa_pkg::MUL_B_W'(held_size_reg);
                            neg_next      = diff[fbpa_pkg::ADDR_W-1];
                            state_next    = S_REL_DIV;
                        end
                        default:
                        begin
                            done_next              = 1'b1;
                            result_next.status     = fbpa_pkg::STATUS_OK;
                            result_next.grant_addr = '0;
                        end
                    endcase
                end
            end

            S_INIT_CHK:
            begin
                if (md_rsp.product > fbpa_pkg::PROD_W'(memory_bytes_reg))
                begin
                    done_next              = 1'b1;
                    result_next.status     = fbpa_pkg::STATUS_NOMEM;
                    result_next.grant_addr = '0;
                    state_next             = S_IDLE;
                end
                else
                begin
                    walk_next  = '0;
                    state_next = S_INIT_WALK;
                end
            end

            S_INIT_WALK:
            begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(walk_reg);
                if (walk_reg == pool_items_reg - fbpa_pkg::ITEMS_W'(1))
                begin
                    ram_wdata              = {fbpa_pkg::LINK_END, IDX_W'(0)};
                    head_valid_next        = 1'b1;
                    head_next              = '0;
                    free_next              = pool_items_reg;
                    limit_next             = pool_items_reg;
                    held_size_next         = block_bytes_reg;
                    held_base_next         = buffer_base_reg;
                    done_next              = 1'b1;
                    result_next.status     = fbpa_pkg::STATUS_OK;
                    result_next.grant_addr = '0;
                    state_next             = S_IDLE;
                end
                else
                begin
                    ram_wdata = {fbpa_pkg::LINK_NEXT, IDX_W'(walk_reg + 1'b1)};
                    walk_next = walk_reg + 1'b1;
                end
            end

            S_GET_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = head_reg;
                ram_wdata = {fbpa_pkg::LINK_TAKEN, IDX_W'(0)};
                if (rd_tag == fbpa_pkg::LINK_NEXT)
                begin
                    head_next = ram_rdata[IDX_W-1:0];
                end
                else
                begin
                    head_valid_next = 1'b0;
                    head_next       = '0;
                end
                if (free_reg != '0)
                begin
                    free_next = free_reg - 1'b1;
                end
                done_next              = 1'b1;
                result_next.status     = fbpa_pkg::STATUS_OK;
                result_next.grant_addr = held_base_reg
                                       + md_rsp.product[fbpa_pkg::ADDR_W-1:0];
                state_next             = S_IDLE;
            end

            S_REL_DIV:
            begin
                if (md_rsp.done)
                begin
                    if (!md_rsp.rem_zero)
                    begin
                        done_next              = 1'b1;
                        result_next.status     = fbpa_pkg::STATUS_UNALIGNED;
                        result_next.grant_addr = '0;
                        state_next             = S_IDLE;
                    end
                    else if (neg_reg ||
                             md_rsp.quotient >= fbpa_pkg::ADDR_W'(limit_reg))
                    begin
                        done_next              = 1'b1;
                        result_next.status     = fbpa_pkg::STATUS_RANGE;
                        result_next.grant_addr = '0;
                        state_next             = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = md_rsp.quotient[IDX_W-1:0];
                        ram_raddr  = md_rsp.quotient[IDX_W-1:0];
                        state_next = S_REL_CHK;
                    end
                end
            end

            S_REL_CHK:
            begin
                done_next              = 1'b1;
                result_next.grant_addr = '0;
                state_next             = S_IDLE;
                if (rd_tag != fbpa_pkg::LINK_TAKEN)
                begin
                    result_next.status = fbpa_pkg::STATUS_DOUBLE;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg;
                    ram_wdata = head_valid_reg ? {fbpa_pkg::LINK_NEXT, head_reg}
                                               : {fbpa_pkg::LINK_END, IDX_W'(0)};
                    head_valid_next    = 1'b1;
                    head_next          = idx_reg;
                    free_next          = free_reg + 1'b1;
                    result_next.status = fbpa_pkg::STATUS_OK;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // every result reports the free count after its request
        if (done_next)
        begin
            result_next.free_count = free_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            head_valid_reg   <= 1'b0;
            head_reg         <= '0;
            free_reg         <= '0;
            limit_reg        <= '0;
            held_size_reg    <= fbpa_pkg::SIZE_W'(16);
            held_base_reg    <= '0;
            done_reg         <= 1'b0;
            block_bytes_reg  <= fbpa_pkg::SIZE_W'(16);
            pool_items_reg   <= fbpa_pkg::ITEMS_W'(1024);
            buffer_base_reg  <= '0;
            memory_bytes_reg <= '1;
        end
        else
        begin
            state_reg      <= state_next;
            head_valid_reg <= head_valid_next;
            head_reg       <= head_next;
            free_reg       <= free_next;
            limit_reg      <= limit_next;
            held_size_reg  <= held_size_next;
            held_base_reg  <= held_base_next;
            done_reg       <= done_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    fbpa_pkg::REG_BLOCK_BYTES:
                    begin
                        block_bytes_reg <= cfg_data[fbpa_pkg::SIZE_W-1:0];
                    end
                    fbpa_pkg::REG_POOL_ITEMS:
                    begin
                        pool_items_reg <= cfg_data[fbpa_pkg::ITEMS_W-1:0];
                    end
                    fbpa_pkg::REG_BUFFER_BASE:
                    begin
                        buffer_base_reg <= cfg_data[fbpa_pkg::ADDR_W-1:0];
                    end
                    fbpa_pkg::REG_MEMORY_BYTES:
                    begin
                        memory_bytes_reg <= cfg_data[fbpa_pkg::ADDR_W-1:0];
                    end
                    default:
                    begin
                        block_bytes_reg <= block_bytes_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        walk_reg   <= walk_next;
        idx_reg    <= idx_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
    end

    fbpa_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .md_req (md_req),
        .md_rsp (md_rsp)
    );

    fbpa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (POOL_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[design/fbpa_checker.sv]
// ----------------------------------------------------------------------------
// fbpa_port_checker
// port-level checks on the allocator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "fixed_block_pool_allocator_core_macros.svh"

module fbpa_port_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                done,
    input wire fbpa_pkg::fbpa_rsp_t result
);

    // an accepted request either keeps the block busy or answers next cycle
    `FBPA_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || done)

    // leaving busy always comes with a result
    `FBPA_ASSERT_NOW(a_busy_fall_done, clk, rst_n, $fell(busy), done)

    // only a successful request may carry a block address
    `FBPA_ASSERT_NOW(a_addr_only_ok, clk, rst_n,
        done && result.status != fbpa_pkg::STATUS_OK, result.grant_addr == '0)

    // empty list means no free blocks
    `FBPA_ASSERT_NOW(a_empty_zero_free, clk, rst_n,
        done && result.status == fbpa_pkg::STATUS_EMPTY, result.free_count == '0)

endmodule

bind fixed_block_pool_allocator_core fbpa_port_checker u_fbpa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire
